### design/emta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Entity mask table allocator package
// Sizes, request/status codes and the command/status bundles shared by the
// controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package emta_pkg;

  localparam int NUM_ENT  = 64;
  localparam int ENT_W    = $clog2(NUM_ENT);
  localparam int FCNT_W   = $clog2(NUM_ENT + 1);
  localparam int MAX_COMP = 15;
  localparam int COMP_W   = 4;
  localparam int FLAG_W   = MAX_COMP + 1;
  localparam int MAX_SYS  = 4;
  localparam int SYS_W    = 2;
  localparam int NSYS_W   = 3;
  localparam int REQ_W    = 3;
  localparam int STAT_W   = 3;
  localparam int CNT_W    = 7;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;
  localparam int REG_W    = 3;

  // request types
  localparam logic [REQ_W-1:0] REQ_CREATE  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DESTROY = 3'd1;
  localparam logic [REQ_W-1:0] REQ_ADD     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REMOVE  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_HAS     = 3'd4;
  localparam logic [REQ_W-1:0] REQ_QUERY   = 3'd5;

  // result status
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_FREE   = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_ALIVE = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_COMP  = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_SYS   = 3'd4;
  localparam logic [STAT_W-1:0] ST_NO_CHANGE = 3'd5;
  localparam logic [STAT_W-1:0] ST_NO_MATCH  = 3'd6;

  // flag memory read address select
  localparam logic [1:0] RD_INPUT = 2'd0;
  localparam logic [1:0] RD_HOLD  = 2'd1;
  localparam logic [1:0] RD_SCAN  = 2'd2;
  localparam logic [1:0] RD_NEXT  = 2'd3;

  // flag word update
  localparam logic [1:0] FOP_ALIVE = 2'd0;
  localparam logic [1:0] FOP_CLEAR = 2'd1;
  localparam logic [1:0] FOP_SET   = 2'd2;
  localparam logic [1:0] FOP_RESET = 2'd3;

  // result payload source
  localparam logic [1:0] OSRC_PLAIN  = 2'd0;
  localparam logic [1:0] OSRC_CREATE = 2'd1;
  localparam logic [1:0] OSRC_HAS    = 2'd2;
  localparam logic [1:0] OSRC_PEND   = 2'd3;

  // configuration register indexes
  localparam logic [REG_W-1:0] REG_NUM_COMP = 3'd0;
  localparam logic [REG_W-1:0] REG_NUM_SYS  = 3'd1;
  localparam logic [REG_W-1:0] REG_SYS0     = 3'd2;
  localparam logic [REG_W-1:0] REG_SYS1     = 3'd3;
  localparam logic [REG_W-1:0] REG_SYS2     = 3'd4;
  localparam logic [REG_W-1:0] REG_SYS3     = 3'd5;

  typedef logic [MAX_SYS-1:0][MAX_COMP-1:0] sys_masks_t;

  typedef struct packed {
    logic              load_req;
    logic [1:0]        rd_sel;
    logic              flag_wr;
    logic [1:0]        flag_op;
    logic              pop;
    logic              push;
    logic              pend_take;
    logic              scan_adv;
    logic              out_load;
    logic [1:0]        out_src;
    logic [STAT_W-1:0] out_status;
    logic              out_last;
  } emta_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             stack_empty;
    logic             stack_full;
    logic             alive;
    logic             comp_ok;
    logic             held;
    logic             sys_ok;
    logic             match;
    logic             pend_valid;
    logic             scan_end;
    logic             out_free;
  } emta_stat_t;

endpackage

### design/emta_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Entity mask table allocator datapath
// Free-id stack, flag word memory, query scan state and the result register.
// ----------------------------------------------------------------------------
module emta_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  emta_pkg::emta_cmd_t                 cmd,
  output emta_pkg::emta_stat_t                stat,
  input  logic [emta_pkg::REQ_W-1:0]          req_type,
  input  logic [emta_pkg::ENT_W-1:0]          entity,
  input  logic [emta_pkg::COMP_W-1:0]         component,
  input  logic [emta_pkg::SYS_W-1:0]          system_index,
  input  logic [emta_pkg::COMP_W-1:0]         num_components,
  input  logic [emta_pkg::NSYS_W-1:0]         num_systems,
  input  emta_pkg::sys_masks_t                sys_required,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [emta_pkg::STAT_W-1:0]         status,
  output logic [emta_pkg::ENT_W-1:0]          entity_out,
  output logic                                present,
  output logic [emta_pkg::CNT_W-1:0]          match_count,
  output logic                                last
);

  // latched request
  logic [emta_pkg::REQ_W-1:0]  req_q;
  logic [emta_pkg::ENT_W-1:0]  ent_q;
  logic [emta_pkg::COMP_W-1:0] comp_q;
  logic [emta_pkg::SYS_W-1:0]  sys_q;

  // query scan
  logic [emta_pkg::ENT_W-1:0]  scan_idx;
  logic                        pend_valid;
  logic [emta_pkg::ENT_W-1:0]  pend_id;
  logic [emta_pkg::CNT_W-1:0]  pend_cnt;

  // free-id stack
  logic [emta_pkg::FCNT_W-1:0] free_count;
  logic [emta_pkg::ENT_W-1:0]  free_mem [emta_pkg::NUM_ENT];
  logic [emta_pkg::NUM_ENT-1:0] free_vld;
  logic [emta_pkg::ENT_W-1:0]  free_raddr;
  logic [emta_pkg::ENT_W-1:0]  free_waddr;
  logic [emta_pkg::ENT_W-1:0]  free_rd_q;
  logic [emta_pkg::ENT_W-1:0]  free_rd_addr_q;
  logic                        free_rd_vld_q;
  logic [emta_pkg::ENT_W-1:0]  rd_free;
  logic                        free_we;

  // flag words
  logic [emta_pkg::FLAG_W-1:0] flag_mem [emta_pkg::NUM_ENT];
  logic [emta_pkg::NUM_ENT-1:0] flag_vld;
  logic [emta_pkg::ENT_W-1:0]  flag_raddr;
  logic [emta_pkg::ENT_W-1:0]  flag_waddr;
  logic [emta_pkg::FLAG_W-1:0] flag_wdata;
  logic [emta_pkg::FLAG_W-1:0] flag_rd_q;
  logic                        flag_rd_vld_q;
  logic [emta_pkg::FLAG_W-1:0] rd_flags;

  logic [emta_pkg::FLAG_W-1:0] cmask;
  logic [emta_pkg::FLAG_W-1:0] need;
  logic                        held;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q  <= req_type;
      ent_q  <= entity;
      comp_q <= component;
      sys_q  <= system_index;
    end
  end

  // --- free-id stack -------------------------------------------------------
  assign free_raddr = free_count[emta_pkg::ENT_W-1:0] - emta_pkg::ENT_W'(1);
  assign free_waddr = free_count[emta_pkg::ENT_W-1:0];
  assign free_we    = cmd.push && !stat.stack_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      free_count <= emta_pkg::FCNT_W'(emta_pkg::NUM_ENT);
    end else if (cmd.pop) begin
      free_count <= free_count - emta_pkg::FCNT_W'(1);
    end else if (free_we) begin
      free_count <= free_count + emta_pkg::FCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (free_we) begin
      free_mem[free_waddr] <= ent_q;
    end
    free_rd_q      <= free_mem[free_raddr];
    free_rd_addr_q <= free_raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_vld      <= '0;
      free_rd_vld_q <= 1'b0;
    end else begin
      if (free_we) begin
        free_vld[free_waddr] <= 1'b1;
      end
      free_rd_vld_q <= free_vld[free_raddr];
    end
  end

  // an unwritten slot still holds its reset id, which is its own index
  assign rd_free = free_rd_vld_q ? free_rd_q : free_rd_addr_q;

  // --- flag word memory ----------------------------------------------------
  always_comb begin
    case (cmd.rd_sel)
      emta_pkg::RD_INPUT: flag_raddr = entity;
      emta_pkg::RD_HOLD:  flag_raddr = ent_q;
      emta_pkg::RD_SCAN:  flag_raddr = scan_idx;
      default:            flag_raddr = scan_idx + emta_pkg::ENT_W'(1);
    endcase
  end

  assign cmask = emta_pkg::FLAG_W'(2) << comp_q;
  assign need  = {sys_required[sys_q], 1'b1};

  always_comb begin
    case (cmd.flag_op)
      emta_pkg::FOP_ALIVE: flag_wdata = emta_pkg::FLAG_W'(1);
      emta_pkg::FOP_CLEAR: flag_wdata = '0;
      emta_pkg::FOP_SET:   flag_wdata = rd_flags | cmask;
      default:             flag_wdata = rd_flags & ~cmask;
    endcase
  end

  assign flag_waddr = (cmd.flag_op == emta_pkg::FOP_ALIVE) ? rd_free : ent_q;

  always_ff @(posedge clk) begin
    if (cmd.flag_wr) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
    flag_rd_q <= flag_mem[flag_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_vld      <= '0;
      flag_rd_vld_q <= 1'b0;
    end else begin
      if (cmd.flag_wr) begin
        flag_vld[flag_waddr] <= 1'b1;
      end
      flag_rd_vld_q <= flag_vld[flag_raddr];
    end
  end

  assign rd_flags = flag_rd_vld_q ? flag_rd_q : '0;
  assign held     = |(rd_flags & cmask);

  // --- query scan ----------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      pend_cnt   <= '0;
      scan_idx   <= '0;
    end else if (cmd.load_req) begin
      pend_valid <= 1'b0;
      pend_cnt   <= '0;
      scan_idx   <= '0;
    end else begin
      if (cmd.pend_take) begin
        pend_valid <= 1'b1;
        pend_cnt   <= pend_cnt + emta_pkg::CNT_W'(1);
      end
      if (cmd.scan_adv) begin
        scan_idx <= scan_idx + emta_pkg::ENT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_take) begin
      pend_id <= scan_idx;
    end
  end

  // --- result register -----------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status <= cmd.out_status;
      last   <= cmd.out_last;
      case (cmd.out_src)
        emta_pkg::OSRC_CREATE: begin
          entity_out  <= rd_free;
          present     <= 1'b0;
          match_count <= '0;
        end
        emta_pkg::OSRC_HAS: begin
          entity_out  <= '0;
          present     <= held;
          match_count <= '0;
        end
        emta_pkg::OSRC_PEND: begin
          entity_out  <= pend_id;
          present     <= 1'b0;
          match_count <= pend_cnt;
        end
        default: begin
          entity_out  <= '0;
          present     <= 1'b0;
          match_count <= '0;
        end
      endcase
    end
  end

  // --- status to controller ------------------------------------------------
  always_comb begin
    stat             = '0;
    stat.req         = req_q;
    stat.stack_empty = (free_count == '0);
    stat.stack_full  = (free_count == emta_pkg::FCNT_W'(emta_pkg::NUM_ENT));
    stat.alive       = rd_flags[0];
    stat.comp_ok     = (comp_q < num_components) &&
                       (comp_q < emta_pkg::COMP_W'(emta_pkg::MAX_COMP));
    stat.held        = held;
    stat.sys_ok      = ({1'b0, sys_q} < num_systems) &&
                       ({1'b0, sys_q} < emta_pkg::NSYS_W'(emta_pkg::MAX_SYS));
    stat.match       = ((rd_flags & need) == need);
    stat.pend_valid  = pend_valid;
    stat.scan_end    = (scan_idx == emta_pkg::ENT_W'(emta_pkg::NUM_ENT - 1));
    stat.out_free    = !out_valid || out_ready;
  end

endmodule

### design/emta_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Entity mask table allocator controller
// Sequences each request: accept, execute, and for queries scan and finish.
// ----------------------------------------------------------------------------
module emta_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  emta_pkg::emta_stat_t stat,
  output emta_pkg::emta_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // a new match must first push the previous one out
  assign stall = stat.match && stat.pend_valid && !stat.out_free;

  always_comb begin
    cmd         = '0;
    cmd.rd_sel  = emta_pkg::RD_HOLD;
    cmd.out_last = 1'b1;
    in_ready    = 1'b0;
    state_next  = state;
    unique case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.rd_sel = emta_pkg::RD_INPUT;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.req == emta_pkg::REQ_QUERY) begin
          cmd.rd_sel = emta_pkg::RD_SCAN;
          if (stat.sys_ok) begin
            state_next = S_SCAN;
          end else if (stat.out_free) begin
            cmd.out_load   = 1'b1;
            cmd.out_status = emta_pkg::ST_BAD_SYS;
            state_next     = S_IDLE;
          end
        end else if (stat.req > emta_pkg::REQ_QUERY) begin
          // unknown request: drop
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_src    = emta_pkg::OSRC_PLAIN;
          cmd.out_status = emta_pkg::ST_OK;
          state_next     = S_IDLE;
          case (stat.req)
            emta_pkg::REQ_CREATE: begin
              if (stat.stack_empty) begin
                cmd.out_status = emta_pkg::ST_NO_FREE;
              end else begin
                cmd.pop     = 1'b1;
                cmd.flag_wr = 1'b1;
                cmd.flag_op = emta_pkg::FOP_ALIVE;
                cmd.out_src = emta_pkg::OSRC_CREATE;
              end
            end
            emta_pkg::REQ_DESTROY: begin
              if (!stat.alive) begin
                cmd.out_status = emta_pkg::ST_NOT_ALIVE;
              end else begin
                cmd.flag_wr = 1'b1;
                cmd.flag_op = emta_pkg::FOP_CLEAR;
                cmd.push    = 1'b1;
              end
            end
            default: begin
              if (!stat.comp_ok) begin
                cmd.out_status = emta_pkg::ST_BAD_COMP;
              end else if (!stat.alive) begin
                cmd.out_status = emta_pkg::ST_NOT_ALIVE;
              end else if (stat.req == emta_pkg::REQ_HAS) begin
                cmd.out_src = emta_pkg::OSRC_HAS;
              end else if (stat.req == emta_pkg::REQ_ADD) begin
                if (stat.held) begin
                  cmd.out_status = emta_pkg::ST_NO_CHANGE;
                end else begin
                  cmd.flag_wr = 1'b1;
                  cmd.flag_op = emta_pkg::FOP_SET;
                end
              end else begin
                if (!stat.held) begin
                  cmd.out_status = emta_pkg::ST_NO_CHANGE;
                end else begin
                  cmd.flag_wr = 1'b1;
                  cmd.flag_op = emta_pkg::FOP_RESET;
                end
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        if (stall || stat.scan_end) begin
          cmd.rd_sel = emta_pkg::RD_SCAN;
        end else begin
          cmd.rd_sel = emta_pkg::RD_NEXT;
        end
        if (!stall) begin
          if (stat.match) begin
            cmd.pend_take = 1'b1;
            if (stat.pend_valid) begin
              cmd.out_load   = 1'b1;
              cmd.out_src    = emta_pkg::OSRC_PEND;
              cmd.out_status = emta_pkg::ST_OK;
              cmd.out_last   = 1'b0;
            end
          end
          if (stat.scan_end) begin
            state_next = S_DONE;
          end else begin
            cmd.scan_adv = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (stat.pend_valid) begin
            cmd.out_src    = emta_pkg::OSRC_PEND;
            cmd.out_status = emta_pkg::ST_OK;
          end else begin
            cmd.out_src    = emta_pkg::OSRC_PLAIN;
            cmd.out_status = emta_pkg::ST_NO_MATCH;
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### design/entity_mask_table_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Entity mask table allocator
// LIFO free entity id allocator with one alive/component flag word per entity,
// component add/remove/test and system queries over all entities.
// ----------------------------------------------------------------------------
//  channel   signals                                        direction
//  request   in_valid/in_ready, req_type, entity,           in
//            component, system_index
//  result    out_valid/out_ready, status, entity_out,       out
//            present, match_count, last
//  config    psel, penable, pwrite, paddr, pwdata,          in/out
//            prdata, pready
//
// Create/destroy/add/remove/has: accept, then one read-modify-write of the
// flag word (registered memory read at accept). In a query the single flag
// memory read port walks one entity per cycle unless stalled by the result
// register, then the held final match is sent with last, or else ST_NO_MATCH.
// Results leave through an output register, so a stalled result only holds the
// block when a further result is ready. Reset is synchronous; valid bits stand
// in for the memory contents, so there is no clearing pass.
// ----------------------------------------------------------------------------
module entity_mask_table_allocator_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [emta_pkg::REQ_W-1:0]          req_type,
  input  logic [emta_pkg::ENT_W-1:0]          entity,
  input  logic [emta_pkg::COMP_W-1:0]         component,
  input  logic [emta_pkg::SYS_W-1:0]          system_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [emta_pkg::STAT_W-1:0]         status,
  output logic [emta_pkg::ENT_W-1:0]          entity_out,
  output logic                                present,
  output logic [emta_pkg::CNT_W-1:0]          match_count,
  output logic                                last,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [emta_pkg::PADDR_W-1:0]        paddr,
  input  logic [emta_pkg::PDATA_W-1:0]        pwdata,
  output logic [emta_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);

  logic [emta_pkg::COMP_W-1:0] num_components;
  logic [emta_pkg::NSYS_W-1:0] num_systems;
  emta_pkg::sys_masks_t        sys_required;
  logic [emta_pkg::REG_W-1:0]  reg_idx;
  logic                        cfg_wr;

  emta_pkg::emta_cmd_t  cmd;
  emta_pkg::emta_stat_t stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[emta_pkg::PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_components <= '0;
      num_systems    <= '0;
      sys_required   <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        emta_pkg::REG_NUM_COMP: num_components <= pwdata[emta_pkg::COMP_W-1:0];
        emta_pkg::REG_NUM_SYS:  num_systems    <= pwdata[emta_pkg::NSYS_W-1:0];
        emta_pkg::REG_SYS0:     sys_required[0] <= pwdata[emta_pkg::MAX_COMP-1:0];
        emta_pkg::REG_SYS1:     sys_required[1] <= pwdata[emta_pkg::MAX_COMP-1:0];
        emta_pkg::REG_SYS2:     sys_required[2] <= pwdata[emta_pkg::MAX_COMP-1:0];
        emta_pkg::REG_SYS3:     sys_required[3] <= pwdata[emta_pkg::MAX_COMP-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      emta_pkg::REG_NUM_COMP: prdata = emta_pkg::PDATA_W'(num_components);
      emta_pkg::REG_NUM_SYS:  prdata = emta_pkg::PDATA_W'(num_systems);
      emta_pkg::REG_SYS0:     prdata = emta_pkg::PDATA_W'(sys_required[0]);
      emta_pkg::REG_SYS1:     prdata = emta_pkg::PDATA_W'(sys_required[1]);
      emta_pkg::REG_SYS2:     prdata = emta_pkg::PDATA_W'(sys_required[2]);
      emta_pkg::REG_SYS3:     prdata = emta_pkg::PDATA_W'(sys_required[3]);
      default:                prdata = '0;
    endcase
  end

  emta_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  emta_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .req_type       (req_type),
    .entity         (entity),
    .component      (component),
    .system_index   (system_index),
    .num_components (num_components),
    .num_systems    (num_systems),
    .sys_required   (sys_required),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .status         (status),
    .entity_out     (entity_out),
    .present        (present),
    .match_count    (match_count),
    .last           (last)
  );

  // never overwrite a result that has not been taken
  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("result register loaded while occupied");

  // unknown request types produce no transaction
  a_unknown_silent: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (req_type > emta_pkg::REQ_QUERY)) |=> !cmd.out_load)
    else $error("result produced for unknown request");

  a_stack_bounds: assert property (@(posedge clk) disable iff (rst)
    !(stat.stack_empty && stat.stack_full))
    else $error("free stack count inconsistent");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in progress");

endmodule

### dv/tb_entity_mask_table_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Entity mask table allocator testbench
// Drives create/destroy/component/query requests through the valid/ready
// request channel and programs the component and system registers over APB.
// A local model of the free-id stack and the per-entity flag words predicts
// every result; each result transaction is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_entity_mask_table_allocator_core;
  import emta_pkg::*;

  localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 80;

  typedef struct packed {
    logic [REQ_W-1:0]  kind;
    logic [ENT_W-1:0]  ent;
    logic [COMP_W-1:0] comp;
    logic [SYS_W-1:0]  sys;
  } table_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ENT_W-1:0]  ent;
    logic              present;
    logic [CNT_W-1:0]  count;
    logic              last;
  } table_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [REQ_W-1:0] req_type = '0;
  logic [ENT_W-1:0] entity = '0;
  logic [COMP_W-1:0] component = '0;
  logic [SYS_W-1:0] system_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STAT_W-1:0] status;
  logic [ENT_W-1:0] entity_out;
  logic present;
  logic [CNT_W-1:0] match_count;
  logic last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  table_req_t req_backlog [$];
  table_result_t due_results [$];

  // model state
  logic [ENT_W-1:0] free_stack [NUM_ENT];
  int free_top;
  logic [FLAG_W-1:0] ent_flags [NUM_ENT];
  logic [COMP_W-1:0] cfg_ncomp;
  logic [NSYS_W-1:0] cfg_nsys;
  logic [MAX_COMP-1:0] cfg_need [MAX_SYS];

  int gap_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  logic req_acc = 1'b0;
  int err_count = 0;

  entity_mask_table_allocator_core DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .entity       (entity),
    .component    (component),
    .system_index (system_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .entity_out   (entity_out),
    .present      (present),
    .match_count  (match_count),
    .last         (last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void owe(input logic [STAT_W-1:0] st, input logic [ENT_W-1:0] e,
                              input logic pres, input logic [CNT_W-1:0] cnt,
                              input logic lst);
    table_result_t r;
    r.status = st;
    r.ent = e;
    r.present = pres;
    r.count = cnt;
    r.last = lst;
    due_results.push_back(r);
  endfunction

  function automatic void table_clear();
    for (int i = 0; i < NUM_ENT; i++) begin
      free_stack[i] = i[ENT_W-1:0];
      ent_flags[i] = '0;
    end
    free_top = NUM_ENT;
    cfg_ncomp = '0;
    cfg_nsys = '0;
    for (int i = 0; i < MAX_SYS; i++) cfg_need[i] = '0;
  endfunction

  // Update the table for one accepted request and queue the results it owes.
  function automatic void table_apply(input table_req_t rq);
    logic comp_ok, alive, held;
    logic [FLAG_W-1:0] cbit, need;
    logic [ENT_W-1:0] id;
    int n_hit, k;
    comp_ok = (rq.comp < cfg_ncomp) && (rq.comp < MAX_COMP);
    alive = ent_flags[rq.ent][0];
    cbit = 16'd1 << (rq.comp + 5'd1);
    held = |(ent_flags[rq.ent] & cbit);
    case (rq.kind)
      REQ_CREATE: begin
        if (free_top == 0) begin
          owe(ST_NO_FREE, '0, 1'b0, '0, 1'b1);
        end else begin
          free_top = free_top - 1;
          id = free_stack[free_top];
          ent_flags[id][0] = 1'b1;
          owe(ST_OK, id, 1'b0, '0, 1'b1);
        end
      end
      REQ_DESTROY: begin
        if (!alive) begin
          owe(ST_NOT_ALIVE, '0, 1'b0, '0, 1'b1);
        end else begin
          ent_flags[rq.ent] = '0;
          if (free_top < NUM_ENT) begin
            free_stack[free_top] = rq.ent;
            free_top = free_top + 1;
          end
          owe(ST_OK, '0, 1'b0, '0, 1'b1);
        end
      end
      REQ_ADD, REQ_REMOVE, REQ_HAS: begin
        if (!comp_ok) begin
          owe(ST_BAD_COMP, '0, 1'b0, '0, 1'b1);
        end else if (!alive) begin
          owe(ST_NOT_ALIVE, '0, 1'b0, '0, 1'b1);
        end else if (rq.kind == REQ_HAS) begin
          owe(ST_OK, '0, held, '0, 1'b1);
        end else if (rq.kind == REQ_ADD) begin
          if (held) begin
            owe(ST_NO_CHANGE, '0, 1'b0, '0, 1'b1);
          end else begin
            ent_flags[rq.ent] = ent_flags[rq.ent] | cbit;
            owe(ST_OK, '0, 1'b0, '0, 1'b1);
          end
        end else begin
          if (!held) begin
            owe(ST_NO_CHANGE, '0, 1'b0, '0, 1'b1);
          end else begin
            ent_flags[rq.ent] = ent_flags[rq.ent] & ~cbit;
            owe(ST_OK, '0, 1'b0, '0, 1'b1);
          end
        end
      end
      REQ_QUERY: begin
        if (rq.sys >= cfg_nsys || rq.sys >= MAX_SYS) begin
          owe(ST_BAD_SYS, '0, 1'b0, '0, 1'b1);
        end else begin
          need = {cfg_need[rq.sys], 1'b1};
          n_hit = 0;
          for (int i = 0; i < NUM_ENT; i++)
            if ((ent_flags[i] & need) == need) n_hit++;
          if (n_hit == 0) begin
            owe(ST_NO_MATCH, '0, 1'b0, '0, 1'b1);
          end else begin
            k = 0;
            for (int i = 0; i < NUM_ENT; i++) begin
              if ((ent_flags[i] & need) == need) begin
                k++;
                owe(ST_OK, i[ENT_W-1:0], 1'b0, k[CNT_W-1:0], k == n_hit);
              end
            end
          end
        end
      end
      default: ;  // reserved codes: no result, no state change
    endcase
  endfunction

  function automatic int alive_count();
    int n;
    n = 0;
    for (int i = 0; i < NUM_ENT; i++) n += int'(ent_flags[i][0]);
    return n;
  endfunction

  // Mostly aim at live entities so that component traffic gets past the checks.
  function automatic logic [ENT_W-1:0] pick_entity();
    logic [ENT_W-1:0] live [$];
    for (int i = 0; i < NUM_ENT; i++)
      if (ent_flags[i][0]) live.push_back(i[ENT_W-1:0]);
    if (live.size() == 0 || $urandom_range(99) < 20)
      return ENT_W'($urandom_range(NUM_ENT - 1));
    return live[$urandom_range(live.size() - 1)];
  endfunction

  function automatic logic [COMP_W-1:0] pick_component();
    if (cfg_ncomp != 0 && $urandom_range(99) < 85)
      return COMP_W'($urandom_range(cfg_ncomp - 1));
    return COMP_W'($urandom_range(15));
  endfunction

  function automatic table_req_t random_req(input int create_pct, input int destroy_pct);
    table_req_t rq;
    int r;
    rq.ent = pick_entity();
    rq.comp = pick_component();
    rq.sys = SYS_W'($urandom_range(MAX_SYS - 1));
    r = $urandom_range(99);
    if (r < create_pct) begin
      rq.kind = REQ_CREATE;
    end else if (r < create_pct + destroy_pct) begin
      rq.kind = REQ_DESTROY;
    end else begin
      r = $urandom_range(99);
      if (r < 30) rq.kind = REQ_ADD;
      else if (r < 50) rq.kind = REQ_REMOVE;
      else if (r < 70) rq.kind = REQ_HAS;
      else if (r < 93) rq.kind = REQ_QUERY;
      else if (r < 97) rq.kind = REQ_RSVD6;
      else rq.kind = REQ_RSVD7;
    end
    return rq;
  endfunction

  function automatic logic [MAX_COMP-1:0] sparse_mask();
    return MAX_COMP'($urandom & $urandom & $urandom);
  endfunction

  task automatic queue_req(input logic [REQ_W-1:0] kind, input logic [ENT_W-1:0] e,
                           input logic [COMP_W-1:0] c, input logic [SYS_W-1:0] s);
    req_backlog.push_back('{kind: kind, ent: e, comp: c, sys: s});
  endtask

  task automatic wait_sender_idle();
    do @(posedge clk); while (req_backlog.size() != 0 || in_valid);
  endtask

  // Reserved request codes owe nothing, so let a full query drain after the last result.
  task automatic wait_results_done();
    do @(posedge clk); while (req_backlog.size() != 0 || in_valid || due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_W-1:0] idx, input logic [PDATA_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_NUM_COMP: cfg_ncomp = val[COMP_W-1:0];
      REG_NUM_SYS:  cfg_nsys = val[NSYS_W-1:0];
      REG_SYS0:     cfg_need[0] = val[MAX_COMP-1:0];
      REG_SYS1:     cfg_need[1] = val[MAX_COMP-1:0];
      REG_SYS2:     cfg_need[2] = val[MAX_COMP-1:0];
      REG_SYS3:     cfg_need[3] = val[MAX_COMP-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int ncomp, input int nsys, input logic [MAX_COMP-1:0] m0,
                            input logic [MAX_COMP-1:0] m1, input logic [MAX_COMP-1:0] m2,
                            input logic [MAX_COMP-1:0] m3);
    wait_results_done();
    write_reg(REG_NUM_COMP, PDATA_W'(ncomp));
    write_reg(REG_NUM_SYS, PDATA_W'(nsys));
    write_reg(REG_SYS0, PDATA_W'(m0));
    write_reg(REG_SYS1, PDATA_W'(m1));
    write_reg(REG_SYS2, PDATA_W'(m2));
    write_reg(REG_SYS3, PDATA_W'(m3));
  endtask

  task automatic run_phase(input int n_items, input int create_pct, input int destroy_pct);
    int sent, batch;
    sent = 0;
    while (sent < n_items) begin
      batch = $urandom_range(8, 30);
      if (batch > n_items - sent) batch = n_items - sent;
      repeat (batch) req_backlog.push_back(random_req(create_pct, destroy_pct));
      sent += batch;
      wait_sender_idle();
      if ($urandom_range(2) == 0) wait_results_done();
    end
    wait_results_done();
  endtask

  // request driver: offer the next request, hold it until accepted
  always @(negedge clk) begin : driver
    table_req_t cur;
    if (!rst && (!in_valid || req_acc)) begin
      if (req_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
        cur = req_backlog.pop_front();
        in_valid <= 1'b1;
        req_type <= cur.kind;
        entity <= cur.ent;
        component <= cur.comp;
        system_index <= cur.sys;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls, plus a requested long hold-off
  always @(negedge clk) begin : receiver
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic check_field(input string what, input logic [CNT_W-1:0] want_v,
                             input logic [CNT_W-1:0] got_v);
    if (got_v !== want_v) begin
      err_count++;
      $display("%0t: %s expected %0d, got %0d", $time, what, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : monitor
    table_result_t want;
    req_acc <= in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready)
        table_apply('{kind: req_type, ent: entity, comp: component, sys: system_index});
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          err_count++;
          $display("%0t: unexpected transaction, expected none, got status %0d entity %0d",
                   $time, status, entity_out);
        end else begin
          want = due_results.pop_front();
          check_field("status", CNT_W'(want.status), CNT_W'(status));
          check_field("entity_out", CNT_W'(want.ent), CNT_W'(entity_out));
          check_field("present", CNT_W'(want.present), CNT_W'(present));
          check_field("match_count", want.count, match_count);
          check_field("last", CNT_W'(want.last), CNT_W'(last));
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("entity_mask_table_allocator_core: mismatch");
    $finish;
  end

  initial begin : stimulus
    int n_fill;
    table_clear();
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // directed: every request kind and the corner statuses
    set_config(15, 4, 15'h0000, 15'h7FFF, 15'h0001, 15'h4001);
    queue_req(REQ_QUERY, 0, 0, 0);     // empty table: no match
    queue_req(REQ_CREATE, 0, 0, 0);
    queue_req(REQ_CREATE, 0, 0, 0);
    queue_req(REQ_HAS, 63, 0, 0);
    queue_req(REQ_ADD, 63, 0, 0);
    queue_req(REQ_ADD, 63, 0, 0);      // already held
    queue_req(REQ_ADD, 63, 14, 0);
    queue_req(REQ_HAS, 63, 14, 0);
    queue_req(REQ_HAS, 63, 15, 0);     // beyond the component limit
    queue_req(REQ_ADD, 0, 1, 0);       // dead entity
    queue_req(REQ_REMOVE, 62, 3, 0);   // absent component
    queue_req(REQ_REMOVE, 63, 0, 0);
    queue_req(REQ_QUERY, 0, 0, 0);
    queue_req(REQ_QUERY, 0, 0, 3);
    queue_req(REQ_ADD, 62, 0, 0);
    queue_req(REQ_QUERY, 0, 0, 2);
    queue_req(REQ_DESTROY, 62, 0, 0);
    queue_req(REQ_DESTROY, 62, 0, 0);  // dead entity
    queue_req(REQ_RSVD6, 5, 1, 1);
    queue_req(REQ_RSVD7, 63, 15, 3);
    queue_req(REQ_CREATE, 0, 0, 0);    // freed id comes back first
    queue_req(REQ_QUERY, 0, 0, 1);
    queue_req(REQ_DESTROY, 63, 0, 0);
    wait_results_done();

    // nothing registered: component and system checks reject the component and query requests
    set_config(0, 0, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
    queue_req(REQ_ADD, 62, 0, 0);
    queue_req(REQ_HAS, 62, 0, 0);
    queue_req(REQ_QUERY, 0, 0, 0);
    queue_req(REQ_DESTROY, 0, 0, 0);
    wait_results_done();

    // create-heavy, then run the stack dry and match every entity
    set_config(15, 4, 15'h0000, sparse_mask(), sparse_mask(), sparse_mask());
    gap_pct = 0;
    stall_pct = 0;
    run_phase(50, 60, 5);
    n_fill = NUM_ENT - alive_count() + 2;
    repeat (n_fill)
      queue_req(REQ_CREATE, ENT_W'($urandom), COMP_W'($urandom), SYS_W'($urandom));
    queue_req(REQ_QUERY, 0, 0, 0);
    queue_req(REQ_QUERY, 0, 0, 3);
    wait_results_done();

    set_config($urandom_range(1, 14), 2, sparse_mask(), sparse_mask(), 15'h7FFF, 15'h0000);
    gap_pct = 49;
    stall_pct = 0;
    run_phase(70, 15, 10);

    // long receiver hold-off while requests keep coming
    set_config(15, 7, sparse_mask(), 15'h0000, sparse_mask(), sparse_mask());
    gap_pct = 0;
    stall_pct = 49;
    hold_req++;
    run_phase(70, 15, 10);

    set_config(1, 4, 15'h0001, 15'h0000, sparse_mask(), sparse_mask());
    gap_pct = 20;
    stall_pct = 20;
    run_phase(70, 10, 35);

    set_config($urandom_range(15), $urandom_range(7), sparse_mask(), sparse_mask(),
               MAX_COMP'($urandom), sparse_mask());
    run_phase(60, 20, 15);

    set_config(15, 4, 15'h0000, 15'h7FFF, sparse_mask(), sparse_mask());
    gap_pct = 0;
    stall_pct = 0;
    run_phase(50, 25, 10);

    if (err_count == 0) begin
      $display("entity_mask_table_allocator_core: match");
    end else begin
      $display("entity_mask_table_allocator_core: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
design/emta_pkg.sv
design/emta_dp.sv
design/emta_ctrl.sv
design/entity_mask_table_allocator_core.sv
dv/tb_entity_mask_table_allocator_core.sv
